// File: hdl/p2sd_pkg.sv
// Package: field widths, fixed-point constants and face rotation codes.
`timescale 1ns / 1ps
package p2sd_pkg;

   localparam int PIXEL_X_W     = 15;
   localparam int PIXEL_Y_W     = 13;
   localparam int FACE_W        = 4;
   localparam int NORM_W        = 16;
   localparam int DIR_W         = 20;
   localparam int CSR_W         = 13;
   localparam int NUM_FACES     = 12;
   localparam int GRID_COLS     = 6;
   localparam int FACE_HEIGHT_RESET = 512;

   localparam int FRAC_BITS_DEFAULT       = 16;
   localparam int MAX_FACE_HEIGHT_DEFAULT = 4096;

   // sqrt(2)/2 in Q30
   localparam longint HALF_SQRT2_Q30 = 759250125;

   typedef logic signed [2:0] rot_code_type;

   // Matrix entry codes: zero, one half, one, sqrt(2)/2; negated for negative entries.
   localparam rot_code_type CODE_ZERO = 3'sd0;
   localparam rot_code_type CODE_HALF = 3'sd1;
   localparam rot_code_type CODE_ONE  = 3'sd2;
   localparam rot_code_type CODE_ROOT = 3'sd3;

   localparam rot_code_type ROT_CODE [NUM_FACES][9] = '{
      '{ CODE_ONE, CODE_ZERO, CODE_ZERO,  CODE_ZERO, CODE_ONE, CODE_ZERO,
         CODE_ZERO, CODE_ZERO, CODE_ONE },
      '{ CODE_HALF, CODE_ROOT, -CODE_HALF,  CODE_ROOT, CODE_ZERO, CODE_ROOT,
         CODE_HALF, -CODE_ROOT, -CODE_HALF },
      '{ CODE_HALF, -CODE_ROOT, -CODE_HALF,  CODE_ROOT, CODE_ZERO, CODE_ROOT,
         -CODE_HALF, -CODE_ROOT, CODE_HALF },
      '{ CODE_HALF, CODE_ROOT, CODE_HALF,  -CODE_ROOT, CODE_ZERO, CODE_ROOT,
         CODE_HALF, -CODE_ROOT, CODE_HALF },
      '{ CODE_HALF, -CODE_ROOT, CODE_HALF,  -CODE_ROOT, CODE_ZERO, CODE_ROOT,
         -CODE_HALF, -CODE_ROOT, -CODE_HALF },
      '{ CODE_ZERO, CODE_ZERO, CODE_ONE,  CODE_ZERO, CODE_ONE, CODE_ZERO,
         -CODE_ONE, CODE_ZERO, CODE_ZERO },
      '{ -CODE_HALF, CODE_ROOT, CODE_HALF,  -CODE_ROOT, CODE_ZERO, -CODE_ROOT,
         -CODE_HALF, -CODE_ROOT, CODE_HALF },
      '{ -CODE_HALF, -CODE_ROOT, CODE_HALF,  CODE_ROOT, CODE_ZERO, CODE_ROOT,
         -CODE_HALF, CODE_ROOT, CODE_HALF },
      '{ -CODE_HALF, -CODE_ROOT, -CODE_HALF,  CODE_ROOT, CODE_ZERO, -CODE_ROOT,
         CODE_HALF, -CODE_ROOT, CODE_HALF },
      '{ -CODE_HALF, CODE_ROOT, -CODE_HALF,  -CODE_ROOT, CODE_ZERO, CODE_ROOT,
         CODE_HALF, CODE_ROOT, CODE_HALF },
      '{ CODE_ZERO, CODE_ZERO, -CODE_ONE,  CODE_ZERO, CODE_ONE, CODE_ZERO,
         CODE_ONE, CODE_ZERO, CODE_ZERO },
      '{ -CODE_ONE, CODE_ZERO, CODE_ZERO,  CODE_ZERO, -CODE_ONE, CODE_ZERO,
         CODE_ZERO, CODE_ZERO, CODE_ONE }
   };

   // sqrt(2)/2 rounded half up to Q frac
   function automatic longint half_sqrt2_q(input int frac);
      return (HALF_SQRT2_Q30 + (longint'(1) << (29 - frac))) >>> (30 - frac);
   endfunction

endpackage

// File: hdl/p2sd_req_if.sv
// Request channel interface: pixel coordinate items.
`timescale 1ns / 1ps
interface p2sd_req_if;
   logic                            valid;
   logic                            ready;
   logic [p2sd_pkg::PIXEL_X_W-1:0]  pixel_x;
   logic [p2sd_pkg::PIXEL_Y_W-1:0]  pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: hdl/p2sd_rsp_if.sv
// Response channel interface: face, fractions and sphere direction items.
`timescale 1ns / 1ps
interface p2sd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [p2sd_pkg::FACE_W-1:0]        face_index;
   logic [p2sd_pkg::NORM_W-1:0]        norm_u;
   logic [p2sd_pkg::NORM_W-1:0]        norm_v;
   logic signed [p2sd_pkg::DIR_W-1:0]  dir_x;
   logic signed [p2sd_pkg::DIR_W-1:0]  dir_y;
   logic signed [p2sd_pkg::DIR_W-1:0]  dir_z;
   logic                               out_of_layout;

   modport source (output valid, output face_index, output norm_u, output norm_v,
                   output dir_x, output dir_y, output dir_z, output out_of_layout,
                   input ready);
   modport sink   (input valid, input face_index, input norm_u, input norm_v,
                   input dir_x, input dir_y, input dir_z, input out_of_layout,
                   output ready);
endinterface

// File: hdl/pixel_to_sphere_direction_core.sv
// Pipeline: grid compare, remainders, quotient stages, M1 to M4, then the response register.
// Throughput: one item per cycle; the quotient pipeline retires one fraction bit per stage.
// The whole pipeline advances together and holds while the response register waits.
// Reset: synchronous, active high; clears all valid bits and loads face height 512
// (clamped to MAX_FACE_HEIGHT). Payload registers are not reset.
`timescale 1ns / 1ps
module pixel_to_sphere_direction_core #(
   parameter int FRAC_BITS       = p2sd_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_FACE_HEIGHT = p2sd_pkg::MAX_FACE_HEIGHT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [p2sd_pkg::CSR_W-1:0]    csr_write_data,
   p2sd_req_if.sink                      req_if,
   p2sd_rsp_if.source                    rsp_if
);

   localparam int F    = FRAC_BITS;
   localparam int HW   = $clog2(MAX_FACE_HEIGHT + 1);
   localparam int MW   = HW + 3;
   localparam int XW   = (MW > p2sd_pkg::PIXEL_X_W) ? MW : p2sd_pkg::PIXEL_X_W;
   localparam int YW   = (MW > p2sd_pkg::PIXEL_Y_W) ? MW : p2sd_pkg::PIXEL_Y_W;
   localparam int HResetVal = (p2sd_pkg::FACE_HEIGHT_RESET > MAX_FACE_HEIGHT) ?
                              MAX_FACE_HEIGHT : p2sd_pkg::FACE_HEIGHT_RESET;
   localparam int CW   = F + 2;          // canonical components
   localparam int DW   = F + 1;          // v - u
   localparam int PW   = 2 * F + 3;      // products with sqrt2/2
   localparam int AW   = 2 * F + 5;      // matrix row sums
   localparam int RW   = AW - F;         // after rounding
   localparam int SW   = (RW > p2sd_pkg::DIR_W) ? RW : p2sd_pkg::DIR_W;
   localparam int UW   = (F > p2sd_pkg::NORM_W) ? F : p2sd_pkg::NORM_W;
   localparam logic signed [F:0] HalfSqrt2 = (F + 1)'(p2sd_pkg::half_sqrt2_q(F));
   localparam logic signed [CW-1:0] OneQ = CW'(longint'(1) << F);
   localparam logic signed [AW-1:0] HalfRound = AW'(longint'(1) << (F - 1));

   // ---------------- face height multiples ----------------
   logic [MW-1:0] mult_ff [1:6];
   logic [HW-1:0] h_clamp;

   always_comb begin
      if (csr_write_data == '0) begin
         h_clamp = HW'(1);
      end else if (32'(csr_write_data) > 32'(MAX_FACE_HEIGHT)) begin
         h_clamp = HW'(MAX_FACE_HEIGHT);
      end else begin
         h_clamp = HW'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 6; k++) begin
         if (reset) begin
            mult_ff[k] <= MW'(k * HResetVal);
         end else if (csr_write_en) begin
            mult_ff[k] <= MW'(k) * MW'(h_clamp);
         end
      end
   end

   logic [HW-1:0] h_cur;
   assign h_cur = mult_ff[1][HW-1:0];

   // ---------------- pipeline control ----------------
   logic advance;
   logic out_valid_ff;
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // ---------------- stage 1: grid compare ----------------
   logic                           s1_valid_ff;
   logic [p2sd_pkg::PIXEL_X_W-1:0] s1_px_ff;
   logic [p2sd_pkg::PIXEL_Y_W-1:0] s1_py_ff;
   logic [2:0]                     s1_col_ff;
   logic                           s1_row_ff;
   logic                           s1_oob_ff;
   logic [2:0]                     col_in;
   logic                           row_in;
   logic                           oob_in;

   always_comb begin
      col_in = '0;
      for (int k = 1; k <= 5; k++) begin
         if (XW'(req_if.pixel_x) >= XW'(mult_ff[k])) begin
            col_in = col_in + 3'd1;
         end
      end
      row_in = YW'(req_if.pixel_y) >= YW'(mult_ff[1]);
      oob_in = (XW'(req_if.pixel_x) >= XW'(mult_ff[6])) ||
               (YW'(req_if.pixel_y) >= YW'(mult_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_if.valid;
      end
      if (advance) begin
         s1_px_ff  <= req_if.pixel_x;
         s1_py_ff  <= req_if.pixel_y;
         s1_col_ff <= col_in;
         s1_row_ff <= row_in;
         s1_oob_ff <= oob_in;
      end
   end

   // ---------------- stage 2: remainders, then quotient stages ----------------
   logic                div_valid_ff [0:F];
   logic                div_oob_ff   [0:F];
   logic [p2sd_pkg::FACE_W-1:0] div_face_ff [0:F];
   logic [HW-1:0]       div_rem_u_ff [0:F];
   logic [HW-1:0]       div_rem_v_ff [0:F];
   logic [F-1:0]        div_q_u_ff   [0:F];
   logic [F-1:0]        div_q_v_ff   [0:F];
   logic [XW-1:0]       col_base;
   logic [XW-1:0]       xm_full;
   logic [YW-1:0]       ym_full;

   always_comb begin
      case (s1_col_ff)
         3'd1:    col_base = XW'(mult_ff[1]);
         3'd2:    col_base = XW'(mult_ff[2]);
         3'd3:    col_base = XW'(mult_ff[3]);
         3'd4:    col_base = XW'(mult_ff[4]);
         3'd5:    col_base = XW'(mult_ff[5]);
         default: col_base = '0;
      endcase
      xm_full = XW'(s1_px_ff) - col_base;
      ym_full = s1_row_ff ? (YW'(s1_py_ff) - YW'(mult_ff[1])) : YW'(s1_py_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= s1_valid_ff;
      end
      if (advance) begin
         div_oob_ff[0]   <= s1_oob_ff;
         div_face_ff[0]  <= p2sd_pkg::FACE_W'({s1_col_ff, s1_row_ff});
         div_rem_u_ff[0] <= xm_full[HW-1:0];
         div_rem_v_ff[0] <= ym_full[HW-1:0];
         div_q_u_ff[0]   <= '0;
         div_q_v_ff[0]   <= '0;
      end
   end

   for (genvar i = 1; i <= F; i++) begin : g_div
      logic [HW:0] sh_u;
      logic [HW:0] sh_v;
      logic        bit_u;
      logic        bit_v;
      logic [HW:0] dif_u;
      logic [HW:0] dif_v;

      always_comb begin
         sh_u  = {div_rem_u_ff[i-1], 1'b0};
         sh_v  = {div_rem_v_ff[i-1], 1'b0};
         bit_u = sh_u >= {1'b0, h_cur};
         bit_v = sh_v >= {1'b0, h_cur};
         dif_u = bit_u ? (sh_u - {1'b0, h_cur}) : sh_u;
         dif_v = bit_v ? (sh_v - {1'b0, h_cur}) : sh_v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[i] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
         if (advance) begin
            div_oob_ff[i]   <= div_oob_ff[i-1];
            div_face_ff[i]  <= div_face_ff[i-1];
            div_rem_u_ff[i] <= dif_u[HW-1:0];
            div_rem_v_ff[i] <= dif_v[HW-1:0];
            div_q_u_ff[i]   <= F'({div_q_u_ff[i-1], bit_u});
            div_q_v_ff[i]   <= F'({div_q_v_ff[i-1], bit_v});
         end
      end
   end

   // ---------------- M1: scale v - u ----------------
   logic                        m1_valid_ff;
   logic                        m1_oob_ff;
   logic [p2sd_pkg::FACE_W-1:0] m1_face_ff;
   logic [F-1:0]                m1_u_ff;
   logic [F-1:0]                m1_v_ff;
   logic signed [PW-1:0]        m1_prod_ff;
   logic signed [DW-1:0]        diff_in;

   assign diff_in = $signed({1'b0, div_q_v_ff[F]}) - $signed({1'b0, div_q_u_ff[F]});

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= div_valid_ff[F];
      end
      if (advance) begin
         m1_oob_ff  <= div_oob_ff[F];
         m1_face_ff <= div_face_ff[F];
         m1_u_ff    <= div_q_u_ff[F];
         m1_v_ff    <= div_q_v_ff[F];
         m1_prod_ff <= PW'(HalfSqrt2) * PW'(diff_in);
      end
   end

   // ---------------- M2: canonical point ----------------
   logic                        m2_valid_ff;
   logic                        m2_oob_ff;
   logic [p2sd_pkg::FACE_W-1:0] m2_face_ff;
   logic [F-1:0]                m2_u_ff;
   logic [F-1:0]                m2_v_ff;
   logic signed [CW-1:0]        m2_c1_ff;
   logic signed [CW-1:0]        m2_c2_ff;
   logic signed [PW-1:0]        prod_rnd;

   assign prod_rnd = (m1_prod_ff + PW'(HalfRound)) >>> F;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (advance) begin
         m2_oob_ff  <= m1_oob_ff;
         m2_face_ff <= m1_face_ff;
         m2_u_ff    <= m1_u_ff;
         m2_v_ff    <= m1_v_ff;
         m2_c1_ff   <= prod_rnd[CW-1:0];
         m2_c2_ff   <= $signed(CW'(m1_u_ff)) + $signed(CW'(m1_v_ff)) - OneQ;
      end
   end

   // ---------------- M3: sqrt2/2 products ----------------
   logic                        m3_valid_ff;
   logic                        m3_oob_ff;
   logic [p2sd_pkg::FACE_W-1:0] m3_face_ff;
   logic [F-1:0]                m3_u_ff;
   logic [F-1:0]                m3_v_ff;
   logic signed [CW-1:0]        m3_c_ff  [3];
   logic signed [PW-1:0]        m3_rt_ff [3];
   logic signed [CW-1:0]        c_vec    [3];

   always_comb begin
      c_vec[0] = OneQ;
      c_vec[1] = m2_c1_ff;
      c_vec[2] = m2_c2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m3_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         m3_oob_ff  <= m2_oob_ff;
         m3_face_ff <= m2_face_ff;
         m3_u_ff    <= m2_u_ff;
         m3_v_ff    <= m2_v_ff;
         for (int j = 0; j < 3; j++) begin
            m3_c_ff[j]  <= c_vec[j];
            m3_rt_ff[j] <= PW'(HalfSqrt2) * PW'(c_vec[j]);
         end
      end
   end

   // ---------------- M4: matrix row sums ----------------
   logic                        m4_valid_ff;
   logic                        m4_oob_ff;
   logic [p2sd_pkg::FACE_W-1:0] m4_face_ff;
   logic [F-1:0]                m4_u_ff;
   logic [F-1:0]                m4_v_ff;
   logic signed [AW-1:0]        m4_acc_ff [3];
   logic signed [AW-1:0]        acc_in    [3];

   always_comb begin
      p2sd_pkg::rot_code_type code;
      p2sd_pkg::rot_code_type mag;
      logic signed [AW-1:0]   term;
      code = p2sd_pkg::CODE_ZERO;
      mag  = p2sd_pkg::CODE_ZERO;
      term = '0;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = '0;
         for (int j = 0; j < 3; j++) begin
            code = p2sd_pkg::ROT_CODE[m3_face_ff][k * 3 + j];
            mag  = (code < 0) ? -code : code;
            case (mag)
               p2sd_pkg::CODE_HALF: term = AW'(m3_c_ff[j]) <<< (F - 1);
               p2sd_pkg::CODE_ONE:  term = AW'(m3_c_ff[j]) <<< F;
               p2sd_pkg::CODE_ROOT: term = AW'(m3_rt_ff[j]);
               default:             term = '0;
            endcase
            acc_in[k] = (code < 0) ? (acc_in[k] - term) : (acc_in[k] + term);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_valid_ff <= 1'b0;
      end else if (advance) begin
         m4_valid_ff <= m3_valid_ff;
      end
      if (advance) begin
         m4_oob_ff  <= m3_oob_ff;
         m4_face_ff <= m3_face_ff;
         m4_u_ff    <= m3_u_ff;
         m4_v_ff    <= m3_v_ff;
         for (int k = 0; k < 3; k++) begin
            m4_acc_ff[k] <= acc_in[k];
         end
      end
   end

   // ---------------- output: round, saturate, response register ----------------
   logic signed [p2sd_pkg::DIR_W-1:0] dir_in  [3];
   logic signed [p2sd_pkg::DIR_W-1:0] dir_ff  [3];
   logic [p2sd_pkg::FACE_W-1:0]       face_ff;
   logic [p2sd_pkg::NORM_W-1:0]       norm_u_ff;
   logic [p2sd_pkg::NORM_W-1:0]       norm_v_ff;
   logic                              oob_ff;
   logic [UW-1:0]                     u_ext;
   logic [UW-1:0]                     v_ext;

   always_comb begin
      logic signed [AW-1:0] rnd;
      logic signed [SW-1:0] wide;
      rnd  = '0;
      wide = '0;
      for (int k = 0; k < 3; k++) begin
         rnd  = (m4_acc_ff[k] + HalfRound) >>> F;
         wide = SW'($signed(rnd[RW-1:0]));
         if (wide > SW'(signed'({1'b0, {(p2sd_pkg::DIR_W - 1){1'b1}}}))) begin
            dir_in[k] = {1'b0, {(p2sd_pkg::DIR_W - 1){1'b1}}};
         end else if (wide < SW'(signed'({1'b1, {(p2sd_pkg::DIR_W - 1){1'b0}}}))) begin
            dir_in[k] = {1'b1, {(p2sd_pkg::DIR_W - 1){1'b0}}};
         end else begin
            dir_in[k] = wide[p2sd_pkg::DIR_W-1:0];
         end
      end
      u_ext = UW'(m4_u_ff);
      v_ext = UW'(m4_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= m4_valid_ff;
      end
      if (advance) begin
         oob_ff    <= m4_oob_ff;
         // zero every field but out_of_layout for pixels outside the grid
         face_ff   <= m4_oob_ff ? '0 : m4_face_ff;
         norm_u_ff <= m4_oob_ff ? '0 : u_ext[p2sd_pkg::NORM_W-1:0];
         norm_v_ff <= m4_oob_ff ? '0 : v_ext[p2sd_pkg::NORM_W-1:0];
         for (int k = 0; k < 3; k++) begin
            dir_ff[k] <= m4_oob_ff ? '0 : dir_in[k];
         end
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.face_index    = face_ff;
   assign rsp_if.norm_u        = norm_u_ff;
   assign rsp_if.norm_v        = norm_v_ff;
   assign rsp_if.dir_x         = dir_ff[0];
   assign rsp_if.dir_y         = dir_ff[1];
   assign rsp_if.dir_z         = dir_ff[2];
   assign rsp_if.out_of_layout = oob_ff;

endmodule

// File: bench/p2sd_checker.sv
// Checker: predicts face, fractions and direction for each pixel and compares.
`timescale 1ns / 1ps
module p2sd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [p2sd_pkg::CSR_W-1:0] csr_write_data,
   p2sd_req_if                        req_if,
   p2sd_rsp_if                        rsp_if,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         rsp_count
);

   localparam int F = p2sd_pkg::FRAC_BITS_DEFAULT;
   localparam longint DIR_MAX = 524287;
   localparam longint DIR_MIN = -524288;

   typedef struct packed {
      logic [p2sd_pkg::FACE_W-1:0]       face_index;
      logic [p2sd_pkg::NORM_W-1:0]       norm_u;
      logic [p2sd_pkg::NORM_W-1:0]       norm_v;
      logic signed [p2sd_pkg::DIR_W-1:0] dir_x;
      logic signed [p2sd_pkg::DIR_W-1:0] dir_y;
      logic signed [p2sd_pkg::DIR_W-1:0] dir_z;
      logic                              out_of_layout;
   } direction_type;

   direction_type expected_dirs[$];
   logic [p2sd_pkg::CSR_W-1:0] face_height;

   // Round half up from Q(F+sh): arithmetic shift floors, so add half first.
   function automatic longint round_half_up(longint x, int sh);
      return (x + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint entry_value(p2sd_pkg::rot_code_type c);
      longint m;
      int mag;
      mag = (c < 0) ? -c : c;
      case (mag)
         p2sd_pkg::CODE_ONE:  m = longint'(1) << F;
         p2sd_pkg::CODE_HALF: m = longint'(1) << (F - 1);
         p2sd_pkg::CODE_ROOT: m = round_half_up(p2sd_pkg::HALF_SQRT2_Q30, 30 - F);
         default:             m = 0;
      endcase
      return (c < 0) ? -m : m;
   endfunction

   function automatic logic signed [p2sd_pkg::DIR_W-1:0] saturate(longint v);
      if (v > DIR_MAX) v = DIR_MAX;
      if (v < DIR_MIN) v = DIR_MIN;
      return v[p2sd_pkg::DIR_W-1:0];
   endfunction

   function automatic direction_type project_pixel(longint px, longint py, longint h_raw);
      direction_type d;
      longint h, col, row, xm, ym, u, v, acc, face;
      longint c[3];
      d = '0;
      h = h_raw;
      if (h == 0) h = 1;
      if (h > p2sd_pkg::MAX_FACE_HEIGHT_DEFAULT) h = p2sd_pkg::MAX_FACE_HEIGHT_DEFAULT;
      if (px >= p2sd_pkg::GRID_COLS * h || py >= 2 * h) begin
         d.out_of_layout = 1'b1;
         return d;
      end
      col = px / h;
      row = py / h;
      xm = px % h;
      ym = py % h;
      face = 2 * col + row;
      u = (xm << F) / h;
      v = (ym << F) / h;
      c[0] = longint'(1) << F;
      c[1] = round_half_up(entry_value(p2sd_pkg::CODE_ROOT) * (v - u), F);
      c[2] = u + v - (longint'(1) << F);
      d.face_index = face[p2sd_pkg::FACE_W-1:0];
      d.norm_u = u[p2sd_pkg::NORM_W-1:0];
      d.norm_v = v[p2sd_pkg::NORM_W-1:0];
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int j = 0; j < 3; j++)
            acc += entry_value(p2sd_pkg::ROT_CODE[face][k*3+j]) * c[j];
         case (k)
            0: d.dir_x = saturate(round_half_up(acc, F));
            1: d.dir_y = saturate(round_half_up(acc, F));
            default: d.dir_z = saturate(round_half_up(acc, F));
         endcase
      end
      return d;
   endfunction

   always @(posedge clock) begin
      direction_type got, want;
      if (reset) begin
         face_height <= p2sd_pkg::CSR_W'(p2sd_pkg::FACE_HEIGHT_RESET);
         expected_dirs.delete();
         mismatch_count = 0;
         rsp_count = 0;
      end else begin
         if (csr_write_en)
            face_height <= csr_write_data;
         if (req_if.valid && req_if.ready)
            expected_dirs.push_back(project_pixel(req_if.pixel_x, req_if.pixel_y,
                                                  face_height));
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            got = '{rsp_if.face_index, rsp_if.norm_u, rsp_if.norm_v, rsp_if.dir_x,
                    rsp_if.dir_y, rsp_if.dir_z, rsp_if.out_of_layout};
            if (expected_dirs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected item %p", got);
            end else begin
               want = expected_dirs.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: item %0d expected %p got %p", rsp_count, want, got);
               end
            end
         end
      end
      pending_count = expected_dirs.size();
   end
endmodule

// File: bench/testbench.sv
// Testbench top: clock, reset, pixel stimulus, face height phases and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int LATENCY = p2sd_pkg::FRAC_BITS_DEFAULT + 7;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [p2sd_pkg::CSR_W-1:0] csr_write_data = '0;
   int mismatch_count, pending_count, rsp_count;
   int sent_count = 0;
   int cur_height = p2sd_pkg::FACE_HEIGHT_RESET;
   bit no_idle = 0;
   bit hold_rsp = 0;

   p2sd_req_if req_if ();
   p2sd_rsp_if rsp_if ();

   pixel_to_sphere_direction_core DUT (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data), .req_if(req_if), .rsp_if(rsp_if));

   p2sd_checker checker_inst (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data), .req_if(req_if), .rsp_if(rsp_if),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .rsp_count(rsp_count));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      rsp_if.ready = 0;
   end

   // Receiver: random stalls, except while a long hold-off is in force (never ready) or no_idle is set (always ready).
   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_if.ready <= 0;
      else
         rsp_if.ready <= no_idle || ($urandom_range(99) >= 16);
   end

   // Called and returns at a falling edge; valid stays up between back-to-back items.
   task automatic send_pixel(int px, int py);
      while (!no_idle && $urandom_range(99) < 16) begin
         req_if.valid <= 0;
         @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.pixel_x <= p2sd_pkg::PIXEL_X_W'(px);
      req_if.pixel_y <= p2sd_pkg::PIXEL_Y_W'(py);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_and_set_height(int h);
      req_if.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      @(negedge clock);
      csr_write_en <= 1;
      csr_write_data <= p2sd_pkg::CSR_W'(h);
      @(negedge clock);
      csr_write_en <= 0;
      cur_height = h;
   endtask

   function automatic int eff_height(int h);
      return (h == 0) ? 1 : (h > p2sd_pkg::MAX_FACE_HEIGHT_DEFAULT ?
                             p2sd_pkg::MAX_FACE_HEIGHT_DEFAULT : h);
   endfunction

   // Mostly inside the grid, with a few at or just past its edge and some anywhere.
   task automatic random_pixels(int n);
      int h, px, py, sel;
      h = eff_height(cur_height);
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(9);
         if (sel < 7) begin
            px = $urandom_range(p2sd_pkg::GRID_COLS * h - 1);
            py = $urandom_range(2 * h - 1);
         end else if (sel < 9) begin
            px = $urandom_range(32767);
            py = $urandom_range(8191);
         end else begin
            px = (p2sd_pkg::GRID_COLS * h > 32767) ? 32767 :
                 p2sd_pkg::GRID_COLS * h - $urandom_range(1);
            py = (2 * h > 8191) ? 8191 : 2 * h - $urandom_range(1);
         end
         send_pixel(px, py);
      end
   endtask

   initial begin
      int h;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: face corners, every face, edges of the grid, field extremes.
      h = p2sd_pkg::FACE_HEIGHT_RESET;
      for (int f = 0; f < p2sd_pkg::NUM_FACES; f++)
         send_pixel((f / 2) * h + h / 3, (f % 2) * h + h / 5);
      send_pixel(0, 0);
      send_pixel(p2sd_pkg::GRID_COLS * h - 1, 2 * h - 1);
      send_pixel(h - 1, 0);
      send_pixel(0, h - 1);
      send_pixel(p2sd_pkg::GRID_COLS * h, 0);
      send_pixel(0, 2 * h);
      send_pixel(32767, 8191);
      send_pixel(h / 2, h / 2);

      // Fill the block while the receiver holds off.
      fork
         begin
            hold_rsp = 1;
            repeat (60) @(posedge clock);
            hold_rsp = 0;
         end
         random_pixels(40);
      join

      drain_and_set_height(0);
      send_pixel(0, 0); send_pixel(5, 1); send_pixel(6, 2); send_pixel(3, 0);
      drain_and_set_height(1);
      random_pixels(20);
      drain_and_set_height(8191);
      send_pixel(24575, 8191); send_pixel(20480, 4096); send_pixel(32767, 0);
      random_pixels(60);
      drain_and_set_height(4096);
      random_pixels(60);
      drain_and_set_height(3);
      random_pixels(120);
      no_idle = 1;
      random_pixels(150);
      no_idle = 0;
      drain_and_set_height(100);
      random_pixels(150);
      drain_and_set_height($urandom_range(4095, 1));
      random_pixels(150);
      drain_and_set_height(p2sd_pkg::FACE_HEIGHT_RESET);
      random_pixels(80);

      req_if.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("Sent %0d pixels and checked %0d results over 8 face heights,",
               sent_count, rsp_count);
      $display("including zero, one, oversized and the maximum face heights.");
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout");
      $display("Verification failed");
      $finish;
   end
endmodule
